@@ hdl/mce_pkg.sv @@
package mce_pkg;

  // Result queue depth; it must hold at least the two results of one event
  localparam int unsigned OUT_DEPTH = 4;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHORD_TICKS = 2'd0,
    CFG_SKEW_X      = 2'd1,
    CFG_SKEW_Y      = 2'd2
  } cfg_idx_t;

  localparam logic [15:0] CHORD_TICKS_RST = 16'd250;
  localparam logic [14:0] SKEW_X_RST      = 15'd2;
  localparam logic [14:0] SKEW_Y_RST      = 15'd2;

  typedef enum logic [2:0] {
    OP_LEFT_DOWN   = 3'd0,
    OP_LEFT_UP     = 3'd1,
    OP_RIGHT_DOWN  = 3'd2,
    OP_RIGHT_UP    = 3'd3,
    OP_MIDDLE_DOWN = 3'd4,
    OP_MIDDLE_UP   = 3'd5,
    OP_MOVE        = 3'd6,
    OP_TICK        = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    KIND_PRESS   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_MOTION  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    BTN_NONE   = 2'd0,
    BTN_LEFT   = 2'd1,
    BTN_MIDDLE = 2'd2,
    BTN_RIGHT  = 2'd3
  } btn_t;

  typedef struct packed {
    logic [15:0] chord_ticks;
    logic [14:0] skew_x;
    logic [14:0] skew_y;
  } cfg_t;

  typedef struct packed {
    op_t                operation;
    logic signed [15:0] pointer_x;
    logic signed [15:0] pointer_y;
    logic [31:0]        event_time;
    logic [2:0]         modifier_keys;
  } item_t;

  typedef struct packed {
    kind_t              event_kind;
    btn_t               button_number;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic [31:0]        out_time;
    logic [2:0]         out_modifiers;
    logic               last_of_run;
  } res_t;

  // Results of one event handed from the decision logic to the queue
  typedef struct packed {
    logic [1:0] cnt;
    res_t       res0;
    res_t       res1;
  } push_t;

  // Input stage control
  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

endpackage

@@ hdl/mce_in_if.sv @@
interface mce_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         operation;
  logic signed [15:0] pointer_x;
  logic signed [15:0] pointer_y;
  logic [31:0]        event_time;
  logic [2:0]         modifier_keys;

  modport source (
    output valid, operation, pointer_x, pointer_y, event_time, modifier_keys,
    input  ready
  );
  modport sink (
    input  valid, operation, pointer_x, pointer_y, event_time, modifier_keys,
    output ready
  );
endinterface

@@ hdl/mce_out_if.sv @@
interface mce_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         event_kind;
  logic [1:0]         button_number;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic [31:0]        out_time;
  logic [2:0]         out_modifiers;
  logic               last_of_run;

  modport source (
    output valid, event_kind, button_number, out_x, out_y, out_time, out_modifiers,
           last_of_run,
    input  ready
  );
  modport sink (
    input  valid, event_kind, button_number, out_x, out_y, out_time, out_modifiers,
           last_of_run,
    output ready
  );
endinterface

@@ hdl/mce_cfg_regs.sv @@
module mce_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              we,
  input  logic [mce_pkg::CFG_IDX_W-1:0]     index,
  input  logic [mce_pkg::CFG_DATA_W-1:0]    wdata,
  output mce_pkg::cfg_t                     cfg
);

  mce_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.chord_ticks <= mce_pkg::CHORD_TICKS_RST;
      cfg_r.skew_x      <= mce_pkg::SKEW_X_RST;
      cfg_r.skew_y      <= mce_pkg::SKEW_Y_RST;
    end else if (we) begin
      case (mce_pkg::cfg_idx_t'(index))
        mce_pkg::CFG_CHORD_TICKS: cfg_r.chord_ticks <= wdata;
        mce_pkg::CFG_SKEW_X:      cfg_r.skew_x      <= wdata[14:0];
        mce_pkg::CFG_SKEW_Y:      cfg_r.skew_y      <= wdata[14:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ hdl/mce_in_stage.sv @@
module mce_in_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  mce_pkg::item_t   in_item,
  input  logic             advance,
  output mce_pkg::stage_t  stage
);

  logic           valid_r;
  mce_pkg::item_t item_r;
  logic           load;

  assign in_ready = !valid_r || advance;
  assign load     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign stage.valid = valid_r;
  assign stage.item  = item_r;

endmodule

@@ hdl/mce_core.sv @@
module mce_core (
  input  logic             clk,
  input  logic             rst_n,
  input  mce_pkg::cfg_t    cfg,
  input  mce_pkg::stage_t  stage,
  input  logic             advance,
  output mce_pkg::push_t   push
);

  logic               await_left_r,  await_left_nxt;
  logic               await_right_r, await_right_nxt;
  logic               chord_r,       chord_nxt;
  logic               skip_left_r,   skip_left_nxt;
  logic               skip_right_r,  skip_right_nxt;
  logic signed [15:0] held_x_r,      held_x_nxt;
  logic signed [15:0] held_y_r,      held_y_nxt;
  logic [31:0]        held_time_r,   held_time_nxt;
  logic [15:0]        countdown_r,   countdown_nxt;

  mce_pkg::item_t     it;
  logic signed [16:0] dx, dy;
  logic [16:0]        adx, ady;
  logic               near;
  logic               is_left;
  logic               await_me, await_other, skip_me;
  mce_pkg::btn_t      me_btn, other_btn;
  mce_pkg::push_t     p;

  function automatic mce_pkg::res_t mk_res(mce_pkg::kind_t k, mce_pkg::btn_t b,
                                           logic signed [15:0] x, logic signed [15:0] y,
                                           logic [31:0] t, logic [2:0] m);
    mce_pkg::res_t r;
    r.event_kind    = k;
    r.button_number = b;
    r.out_x         = x;
    r.out_y         = y;
    r.out_time      = t;
    r.out_modifiers = m;
    r.last_of_run   = 1'b0;
    return r;
  endfunction

  assign it = stage.item;

  // Distance from the held press point
  always_comb begin
    dx   = {held_x_r[15], held_x_r} - {it.pointer_x[15], it.pointer_x};
    dy   = {held_y_r[15], held_y_r} - {it.pointer_y[15], it.pointer_y};
    adx  = dx[16] ? 17'(-dx) : 17'(dx);
    ady  = dy[16] ? 17'(-dy) : 17'(dy);
    near = (adx < {2'b00, cfg.skew_x}) && (ady < {2'b00, cfg.skew_y});
  end

  always_comb begin
    is_left     = (it.operation == mce_pkg::OP_LEFT_DOWN) ||
                  (it.operation == mce_pkg::OP_LEFT_UP);
    await_me    = is_left ? await_left_r  : await_right_r;
    await_other = is_left ? await_right_r : await_left_r;
    skip_me     = is_left ? skip_left_r   : skip_right_r;
    me_btn      = is_left ? mce_pkg::BTN_LEFT  : mce_pkg::BTN_RIGHT;
    other_btn   = is_left ? mce_pkg::BTN_RIGHT : mce_pkg::BTN_LEFT;
  end

  always_comb begin
    await_left_nxt  = await_left_r;
    await_right_nxt = await_right_r;
    chord_nxt       = chord_r;
    skip_left_nxt   = skip_left_r;
    skip_right_nxt  = skip_right_r;
    held_x_nxt      = held_x_r;
    held_y_nxt      = held_y_r;
    held_time_nxt   = held_time_r;
    countdown_nxt   = countdown_r;
    p.cnt  = 2'd0;
    p.res0 = mk_res(mce_pkg::KIND_MOTION, mce_pkg::BTN_NONE, it.pointer_x, it.pointer_y,
                    it.event_time, it.modifier_keys);
    p.res1 = p.res0;

    case (it.operation)
      mce_pkg::OP_LEFT_DOWN, mce_pkg::OP_RIGHT_DOWN: begin
        held_time_nxt = it.event_time;
        if (await_me) begin
          // second press: chord, or two separate presses
          countdown_nxt   = '0;
          await_left_nxt  = 1'b0;
          await_right_nxt = 1'b0;
          if (near) begin
            chord_nxt = 1'b1;
            p.cnt  = 2'd1;
            p.res0 = mk_res(mce_pkg::KIND_PRESS, mce_pkg::BTN_MIDDLE, it.pointer_x,
                            it.pointer_y, it.event_time, it.modifier_keys);
          end else begin
            p.cnt  = 2'd2;
            p.res0 = mk_res(mce_pkg::KIND_PRESS, other_btn, held_x_r, held_y_r,
                            held_time_r, it.modifier_keys);
            p.res1 = mk_res(mce_pkg::KIND_PRESS, me_btn, it.pointer_x, it.pointer_y,
                            it.event_time, it.modifier_keys);
          end
        end else begin
          countdown_nxt = (cfg.chord_ticks != '0) ? cfg.chord_ticks : 16'd1;
          if (is_left) await_right_nxt = 1'b1;
          else         await_left_nxt  = 1'b1;
          held_x_nxt = it.pointer_x;
          held_y_nxt = it.pointer_y;
        end
      end
      mce_pkg::OP_LEFT_UP, mce_pkg::OP_RIGHT_UP: begin
        held_time_nxt = it.event_time;
        countdown_nxt = '0;
        if (is_left) await_left_nxt  = 1'b0;
        else         await_right_nxt = 1'b0;
        if (skip_me) begin
          if (is_left) skip_left_nxt  = 1'b0;
          else         skip_right_nxt = 1'b0;
        end else if (chord_r) begin
          chord_nxt = 1'b0;
          if (is_left) skip_right_nxt = 1'b1;
          else         skip_left_nxt  = 1'b1;
          p.cnt  = 2'd1;
          p.res0 = mk_res(mce_pkg::KIND_RELEASE, mce_pkg::BTN_MIDDLE, it.pointer_x,
                          it.pointer_y, it.event_time, it.modifier_keys);
        end else if (await_other) begin
          if (is_left) await_right_nxt = 1'b0;
          else         await_left_nxt  = 1'b0;
          p.cnt  = 2'd2;
          p.res0 = mk_res(mce_pkg::KIND_PRESS, me_btn, it.pointer_x, it.pointer_y,
                          it.event_time, it.modifier_keys);
          p.res1 = mk_res(mce_pkg::KIND_RELEASE, me_btn, it.pointer_x, it.pointer_y,
                          it.event_time, it.modifier_keys);
        end else begin
          p.cnt  = 2'd1;
          p.res0 = mk_res(mce_pkg::KIND_RELEASE, me_btn, it.pointer_x, it.pointer_y,
                          it.event_time, it.modifier_keys);
        end
      end
      mce_pkg::OP_MIDDLE_DOWN: begin
        p.cnt  = 2'd1;
        p.res0 = mk_res(mce_pkg::KIND_PRESS, mce_pkg::BTN_MIDDLE, it.pointer_x,
                        it.pointer_y, it.event_time, it.modifier_keys);
      end
      mce_pkg::OP_MIDDLE_UP: begin
        p.cnt  = 2'd1;
        p.res0 = mk_res(mce_pkg::KIND_RELEASE, mce_pkg::BTN_MIDDLE, it.pointer_x,
                        it.pointer_y, it.event_time, it.modifier_keys);
      end
      mce_pkg::OP_MOVE: begin
        p.cnt = 2'd1;
        if ((await_left_r || await_right_r) && !near) begin
          // flush the held press, then the motion
          countdown_nxt = '0;
          p.cnt = 2'd2;
          p.res1 = p.res0;
          if (await_left_r) begin
            await_left_nxt = 1'b0;
            p.res0 = mk_res(mce_pkg::KIND_PRESS, mce_pkg::BTN_RIGHT, held_x_r, held_y_r,
                            held_time_r, it.modifier_keys);
          end else begin
            await_right_nxt = 1'b0;
            p.res0 = mk_res(mce_pkg::KIND_PRESS, mce_pkg::BTN_LEFT, held_x_r, held_y_r,
                            held_time_r, it.modifier_keys);
          end
        end
      end
      mce_pkg::OP_TICK: begin
        if (countdown_r != '0) begin
          countdown_nxt = countdown_r - 16'd1;
          if (countdown_r == 16'd1) begin
            if (await_left_r) begin
              await_left_nxt = 1'b0;
              p.cnt  = 2'd1;
              p.res0 = mk_res(mce_pkg::KIND_PRESS, mce_pkg::BTN_RIGHT, held_x_r, held_y_r,
                              held_time_r, it.modifier_keys);
            end else if (await_right_r) begin
              await_right_nxt = 1'b0;
              p.cnt  = 2'd1;
              p.res0 = mk_res(mce_pkg::KIND_PRESS, mce_pkg::BTN_LEFT, held_x_r, held_y_r,
                              held_time_r, it.modifier_keys);
            end
          end
        end
      end
      default: ;
    endcase

    p.res0.last_of_run = (p.cnt == 2'd1);
    p.res1.last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      await_left_r  <= 1'b0;
      await_right_r <= 1'b0;
      chord_r       <= 1'b0;
      skip_left_r   <= 1'b0;
      skip_right_r  <= 1'b0;
      held_x_r      <= '0;
      held_y_r      <= '0;
      held_time_r   <= '0;
      countdown_r   <= '0;
    end else if (stage.valid && advance) begin
      await_left_r  <= await_left_nxt;
      await_right_r <= await_right_nxt;
      chord_r       <= chord_nxt;
      skip_left_r   <= skip_left_nxt;
      skip_right_r  <= skip_right_nxt;
      held_x_r      <= held_x_nxt;
      held_y_r      <= held_y_nxt;
      held_time_r   <= held_time_nxt;
      countdown_r   <= countdown_nxt;
    end
  end

  always_comb begin
    push     = p;
    push.cnt = (stage.valid && advance) ? p.cnt : 2'd0;
  end

endmodule

@@ hdl/mce_out_fifo.sv @@
module mce_out_fifo #(
  parameter int unsigned DEPTH = mce_pkg::OUT_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  mce_pkg::push_t  push,
  output logic            advance,
  output logic            out_valid,
  input  logic            out_ready,
  output mce_pkg::res_t   out_res
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  mce_pkg::res_t mem [DEPTH];

  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;
  logic [PTR_W-1:0] wr_ptr_1;
  logic             pop;

  function automatic logic [PTR_W-1:0] inc_ptr(logic [PTR_W-1:0] ptr);
    return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
  endfunction

  // Room for the largest burst of one event
  assign advance   = (count_r <= CNT_W'(DEPTH - 2));
  assign out_valid = (count_r != '0);
  assign pop       = out_valid && out_ready;
  assign out_res   = mem[rd_ptr_r];
  assign wr_ptr_1  = inc_ptr(wr_ptr_r);

  always_comb begin
    rd_ptr_nxt = pop ? inc_ptr(rd_ptr_r) : rd_ptr_r;
    case (push.cnt)
      2'd1:    wr_ptr_nxt = wr_ptr_1;
      2'd2:    wr_ptr_nxt = inc_ptr(wr_ptr_1);
      default: wr_ptr_nxt = wr_ptr_r;
    endcase
    count_nxt = count_r + CNT_W'(push.cnt) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_ptr_r] <= push.res0;
    end
    if (push.cnt == 2'd2) begin
      mem[wr_ptr_1] <= push.res1;
    end
  end

endmodule

@@ hdl/mouse_chord_middle_button_emulator_top.sv @@
// Three-button mouse emulation: a left and right press that arrive within the chord time
// (chord_ticks timer ticks) and closer than skew_x/skew_y to each other come out as one
// middle press; releasing either button then reports a middle release and the other
// button's release is dropped. A single held press is flushed as a real press when the
// countdown expires or the pointer moves outside the skew window. One event transaction
// is taken every clock cycle while the result queue has room for two results; each event
// produces zero, one or two result transactions, and results leave at one per cycle
// while the receiver is ready, so the two results of an event leave one after the other.
// An accepted event is held in the input register, and the combinational decision logic
// writes its results into the result queue (OUT_DEPTH entries) as the event leaves it.
// Input ready drops only when that queue cannot take another two results. Configuration
// writes take effect on the next cycle and belong between bursts of events.
module mouse_chord_middle_button_emulator_top #(
  parameter int unsigned OUT_DEPTH = mce_pkg::OUT_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  mce_in_if.sink                         in_evt,
  mce_out_if.source                      out_evt,
  input  logic                           cfg_we,
  input  logic [mce_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mce_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  mce_pkg::cfg_t   cfg;
  mce_pkg::item_t  in_item;
  mce_pkg::stage_t stage;
  mce_pkg::push_t  push;
  mce_pkg::res_t   out_res;
  logic            advance;

  // Register file for chord time and skew window
  mce_cfg_regs u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (cfg_we),
    .index (cfg_index),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  // Pack the incoming event
  assign in_item.operation     = mce_pkg::op_t'(in_evt.operation);
  assign in_item.pointer_x     = in_evt.pointer_x;
  assign in_item.pointer_y     = in_evt.pointer_y;
  assign in_item.event_time    = in_evt.event_time;
  assign in_item.modifier_keys = in_evt.modifier_keys;

  // Input register; holds an event while the result queue is too full
  mce_in_stage u_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_evt.valid),
    .in_ready (in_evt.ready),
    .in_item  (in_item),
    .advance  (advance),
    .stage    (stage)
  );

  // Chord state and result selection
  mce_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .stage   (stage),
    .advance (advance),
    .push    (push)
  );

  // Result queue; advance means room for two results
  mce_out_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .advance   (advance),
    .out_valid (out_evt.valid),
    .out_ready (out_evt.ready),
    .out_res   (out_res)
  );

  assign out_evt.event_kind    = out_res.event_kind;
  assign out_evt.button_number = out_res.button_number;
  assign out_evt.out_x         = out_res.out_x;
  assign out_evt.out_y         = out_res.out_y;
  assign out_evt.out_time      = out_res.out_time;
  assign out_evt.out_modifiers = out_res.out_modifiers;
  assign out_evt.last_of_run   = out_res.last_of_run;

  // Results are pushed only for an event that leaves the input register
  a_push_needs_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt != 2'd0) |-> (stage.valid && advance))
    else $error("results pushed without an event leaving the input register");

  // Middle button events and ticks never produce two results
  a_two_only_for_lr_move: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt == 2'd2) |-> (stage.item.operation != mce_pkg::OP_MIDDLE_DOWN &&
                            stage.item.operation != mce_pkg::OP_MIDDLE_UP &&
                            stage.item.operation != mce_pkg::OP_TICK))
    else $error("two results from a middle button event or tick");

  // Exactly one result of a burst carries the last-of-run mark
  a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt == 2'd2) |-> (!push.res0.last_of_run && push.res1.last_of_run))
    else $error("last-of-run mark misplaced in a two-result burst");

  // A stalled input side means an event is waiting in the input register
  a_stall_has_event: assert property (@(posedge clk) disable iff (!rst_n)
    !in_evt.ready |-> stage.valid)
    else $error("input stalled with an empty input register");

  // An accepted event is in the input register on the next cycle
  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_evt.valid && in_evt.ready) |=> stage.valid)
    else $error("accepted event did not reach the input register");

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
module tb_top;
  import mce_pkg::*;

  localparam int CLK_HALF         = 10;
  localparam int RESET_CYCLES     = 7;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int HOLD_OFF_CYCLES  = 80;
  localparam int SETTLE_CYCLES    = 6;
  localparam int EVENTS_PER_PHASE = 200;

  // Tracks the chord emulation state and holds the mouse reports still owed by the block.
  class chord_scoreboard;
    logic [15:0]        chord_ticks;
    logic [14:0]        skew_x;
    logic [14:0]        skew_y;
    bit                 need_left;
    bit                 need_right;
    bit                 chording;
    bit                 swallow_left_up;
    bit                 swallow_right_up;
    logic signed [15:0] held_x;
    logic signed [15:0] held_y;
    logic [31:0]        held_time;
    logic [15:0]        ticks_left;
    res_t               reports_due[$];
    res_t               batch[$];
    int                 errors;

    function new();
      chord_ticks      = CHORD_TICKS_RST;
      skew_x           = SKEW_X_RST;
      skew_y           = SKEW_Y_RST;
      need_left        = 1'b0;
      need_right       = 1'b0;
      chording         = 1'b0;
      swallow_left_up  = 1'b0;
      swallow_right_up = 1'b0;
      held_x           = '0;
      held_y           = '0;
      held_time        = '0;
      ticks_left       = '0;
      errors           = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [15:0] val);
      case (idx)
        CFG_CHORD_TICKS: chord_ticks = val;
        CFG_SKEW_X:      skew_x = val[14:0];
        CFG_SKEW_Y:      skew_y = val[14:0];
        default: ;
      endcase
    endfunction

    function bit close_to_held(logic signed [15:0] x, logic signed [15:0] y);
      int dx;
      int dy;
      dx = int'(held_x) - int'(x);
      dy = int'(held_y) - int'(y);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      return (dx < int'(skew_x)) && (dy < int'(skew_y));
    endfunction

    function void queue_report(kind_t k, btn_t b, logic signed [15:0] x,
                               logic signed [15:0] y, logic [31:0] t, logic [2:0] m);
      res_t r;
      r.event_kind    = k;
      r.button_number = b;
      r.out_x         = x;
      r.out_y         = y;
      r.out_time      = t;
      r.out_modifiers = m;
      r.last_of_run   = 1'b0;
      batch.push_back(r);
    endfunction

    function void report_held_press(logic [2:0] m);
      ticks_left = '0;
      if (need_left) begin
        need_left = 1'b0;
        queue_report(KIND_PRESS, BTN_RIGHT, held_x, held_y, held_time, m);
      end else if (need_right) begin
        need_right = 1'b0;
        queue_report(KIND_PRESS, BTN_LEFT, held_x, held_y, held_time, m);
      end
    endfunction

    function void button_down(bit is_left, item_t it);
      bit   mine;
      btn_t me;
      btn_t other;
      mine  = is_left ? need_left : need_right;
      me    = is_left ? BTN_LEFT : BTN_RIGHT;
      other = is_left ? BTN_RIGHT : BTN_LEFT;
      if (mine) begin
        ticks_left = '0;
        need_left  = 1'b0;
        need_right = 1'b0;
        if (close_to_held(it.pointer_x, it.pointer_y)) begin
          chording = 1'b1;
          queue_report(KIND_PRESS, BTN_MIDDLE, it.pointer_x, it.pointer_y, it.event_time,
                       it.modifier_keys);
        end else begin
          queue_report(KIND_PRESS, other, held_x, held_y, held_time, it.modifier_keys);
          queue_report(KIND_PRESS, me, it.pointer_x, it.pointer_y, it.event_time,
                       it.modifier_keys);
        end
      end else begin
        ticks_left = (chord_ticks != 16'd0) ? chord_ticks : 16'd1;
        if (is_left) need_right = 1'b1;
        else need_left = 1'b1;
        held_x = it.pointer_x;
        held_y = it.pointer_y;
      end
      held_time = it.event_time;
    endfunction

    function void button_up(bit is_left, item_t it);
      btn_t me;
      bit   swallow;
      bit   other_held;
      me         = is_left ? BTN_LEFT : BTN_RIGHT;
      held_time  = it.event_time;
      ticks_left = '0;
      if (is_left) need_left = 1'b0;
      else need_right = 1'b0;
      swallow    = is_left ? swallow_left_up : swallow_right_up;
      other_held = is_left ? need_right : need_left;
      if (swallow) begin
        if (is_left) swallow_left_up = 1'b0;
        else swallow_right_up = 1'b0;
      end else if (chording) begin
        chording = 1'b0;
        if (is_left) swallow_right_up = 1'b1;
        else swallow_left_up = 1'b1;
        queue_report(KIND_RELEASE, BTN_MIDDLE, it.pointer_x, it.pointer_y, it.event_time,
                     it.modifier_keys);
      end else begin
        if (other_held) begin
          if (is_left) need_right = 1'b0;
          else need_left = 1'b0;
          queue_report(KIND_PRESS, me, it.pointer_x, it.pointer_y, it.event_time,
                       it.modifier_keys);
        end
        queue_report(KIND_RELEASE, me, it.pointer_x, it.pointer_y, it.event_time,
                     it.modifier_keys);
      end
    endfunction

    function void note_event(item_t it);
      res_t tail;
      batch.delete();
      case (it.operation)
        OP_LEFT_DOWN:   button_down(1'b1, it);
        OP_LEFT_UP:     button_up(1'b1, it);
        OP_RIGHT_DOWN:  button_down(1'b0, it);
        OP_RIGHT_UP:    button_up(1'b0, it);
        OP_MIDDLE_DOWN: queue_report(KIND_PRESS, BTN_MIDDLE, it.pointer_x, it.pointer_y,
                                     it.event_time, it.modifier_keys);
        OP_MIDDLE_UP:   queue_report(KIND_RELEASE, BTN_MIDDLE, it.pointer_x, it.pointer_y,
                                     it.event_time, it.modifier_keys);
        OP_MOVE: begin
          if ((need_left || need_right) && !close_to_held(it.pointer_x, it.pointer_y))
            report_held_press(it.modifier_keys);
          queue_report(KIND_MOTION, BTN_NONE, it.pointer_x, it.pointer_y, it.event_time,
                       it.modifier_keys);
        end
        default: begin
          if (ticks_left != 16'd0) begin
            ticks_left = ticks_left - 16'd1;
            if (ticks_left == 16'd0) report_held_press(it.modifier_keys);
          end
        end
      endcase
      if (batch.size() != 0) begin
        tail = batch.pop_back();
        tail.last_of_run = 1'b1;
        batch.push_back(tail);
      end
      foreach (batch[i]) reports_due.push_back(batch[i]);
    endfunction

    task report(string msg);
      errors++;
      $display("%0t ns mismatch: %s", $time, msg);
    endtask

    task compare_field(string name, logic [31:0] got_v, logic [31:0] want_v);
      if (got_v !== want_v)
        report($sformatf("%s got %0h expected %0h", name, got_v, want_v));
    endtask

    task check_result(res_t got);
      res_t want;
      if (reports_due.size() == 0) begin
        report($sformatf("unexpected result kind %0d button %0d", got.event_kind,
                         got.button_number));
        return;
      end
      want = reports_due.pop_front();
      compare_field("event_kind", got.event_kind, want.event_kind);
      compare_field("button_number", got.button_number, want.button_number);
      compare_field("out_x", got.out_x, want.out_x);
      compare_field("out_y", got.out_y, want.out_y);
      compare_field("out_time", got.out_time, want.out_time);
      compare_field("out_modifiers", got.out_modifiers, want.out_modifiers);
      compare_field("last_of_run", got.last_of_run, want.last_of_run);
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  mce_in_if  ev_in ();
  mce_out_if ev_out ();

  chord_scoreboard mouse_sb = new();

  bit in_idle;       // sender inserts random gaps
  bit out_idle;      // receiver drops ready at random
  bit hold_off_req;  // ask the receiver for one long stall
  int events_sent;   // events accepted in the current phase
  int quiet_cycles;  // cycles since the last transaction on either channel

  mouse_chord_middle_button_emulator_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_evt    (ev_in),
    .out_evt   (ev_out),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Monitor: sample both channels at the rising edge. Inputs are noted before results are
  // checked; a result can never belong to an event accepted at the same edge.
  always @(posedge clk) begin
    item_t it;
    res_t  r;
    bit    in_hit;
    bit    out_hit;
    in_hit  = rst_n && ev_in.valid && ev_in.ready;
    out_hit = rst_n && ev_out.valid && ev_out.ready;
    if (in_hit) begin
      it.operation     = op_t'(ev_in.operation);
      it.pointer_x     = ev_in.pointer_x;
      it.pointer_y     = ev_in.pointer_y;
      it.event_time    = ev_in.event_time;
      it.modifier_keys = ev_in.modifier_keys;
      mouse_sb.note_event(it);
    end
    if (out_hit) begin
      r.event_kind    = kind_t'(ev_out.event_kind);
      r.button_number = btn_t'(ev_out.button_number);
      r.out_x         = ev_out.out_x;
      r.out_y         = ev_out.out_y;
      r.out_time      = ev_out.out_time;
      r.out_modifiers = ev_out.out_modifiers;
      r.last_of_run   = ev_out.last_of_run;
      mouse_sb.check_result(r);
    end
    if (in_hit || out_hit) quiet_cycles = 0;
    else quiet_cycles++;
  end

  // Watchdog: end the run when the channels stay silent far longer than any legal stall.
  initial begin
    quiet_cycles = 0;
    @(negedge clk);
    while (quiet_cycles < WATCHDOG_LIMIT) @(negedge clk);
    $display("== FAIL ==");
    $finish;
  end

  // Receiver: drive ready once per falling edge. A hold-off request holds ready low until
  // hold_off_req clears, so the result queue fills and the input side backs up.
  initial begin
    ev_out.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        ev_out.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end
      ev_out.ready <= out_idle ? ($urandom_range(99) >= 35) : 1'b1;
    end
  end

  // Offer one event transaction; called at a falling edge, returns at the falling edge
  // after acceptance with valid still high.
  task automatic send_event(input op_t op, input logic signed [15:0] x,
                            input logic signed [15:0] y, input logic [31:0] t,
                            input logic [2:0] m);
    while (in_idle && ($urandom_range(99) < 35)) begin
      ev_in.valid <= 1'b0;
      @(negedge clk);
    end
    ev_in.valid         <= 1'b1;
    ev_in.operation     <= op;
    ev_in.pointer_x     <= x;
    ev_in.pointer_y     <= y;
    ev_in.event_time    <= t;
    ev_in.modifier_keys <= m;
    @(posedge clk);
    while (!ev_in.ready) @(posedge clk);
    events_sent++;
    @(negedge clk);
  endtask

  task automatic send_rand(input op_t op, input logic signed [15:0] x,
                           input logic signed [15:0] y);
    send_event(op, x, y, $urandom(), 3'($urandom_range(7)));
  endtask

  // Drop valid, wait for every owed report, then give the pipeline time to go quiet
  // (a trailing tick yields nothing but may still be in flight).
  task automatic settle();
    ev_in.valid <= 1'b0;
    while (mouse_sb.reports_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    mouse_sb.set_reg(idx, val);
    @(negedge clk);
  endtask

  // Point near the given one in the current skew window; occasionally on the window
  // edge, and now and then anywhere at all.
  function automatic logic signed [15:0] nudge(input logic signed [15:0] v);
    int span;
    int off;
    span = (mouse_sb.skew_x < mouse_sb.skew_y) ? mouse_sb.skew_x : mouse_sb.skew_y;
    if (span > 24) span = 24;
    if ($urandom_range(9) == 0) return 16'($urandom());
    off = (span == 0) ? 0 : int'($urandom_range(0, 2 * span)) - span;
    return 16'(int'(v) + off);
  endfunction

  // Ticks and moves between button transactions; with a short chord time, often run the
  // countdown out on purpose.
  task automatic dawdle(input logic signed [15:0] px, input logic signed [15:0] py);
    int n;
    if ((mouse_sb.chord_ticks <= 6) && ($urandom_range(2) == 0)) begin
      repeat (int'(mouse_sb.chord_ticks) + 1)
        send_rand(OP_TICK, 16'($urandom()), 16'($urandom()));
    end else begin
      n = $urandom_range(0, 3);
      repeat (n) begin
        if ($urandom_range(1)) send_rand(OP_TICK, 16'($urandom()), 16'($urandom()));
        else send_rand(OP_MOVE, nudge(px), nudge(py));
      end
    end
  endtask

  // One gesture: mostly chords and clicks with random content, some noise.
  task automatic play_gesture();
    int                 pick;
    int                 n;
    bit                 left_first;
    op_t                dn_a;
    op_t                dn_b;
    op_t                up_a;
    op_t                up_b;
    op_t                swap;
    logic signed [15:0] px;
    logic signed [15:0] py;
    pick       = $urandom_range(99);
    left_first = $urandom_range(1);
    dn_a       = left_first ? OP_LEFT_DOWN : OP_RIGHT_DOWN;
    dn_b       = left_first ? OP_RIGHT_DOWN : OP_LEFT_DOWN;
    up_a       = left_first ? OP_LEFT_UP : OP_RIGHT_UP;
    up_b       = left_first ? OP_RIGHT_UP : OP_LEFT_UP;
    px         = 16'($urandom());
    py         = 16'($urandom());
    if (pick < 45) begin
      send_rand(dn_a, px, py);
      dawdle(px, py);
      send_rand(dn_b, nudge(px), nudge(py));
      dawdle(px, py);
      if ($urandom_range(1)) begin
        swap = up_a;
        up_a = up_b;
        up_b = swap;
      end
      send_rand(up_a, nudge(px), nudge(py));
      dawdle(px, py);
      send_rand(up_b, nudge(px), nudge(py));
    end else if (pick < 70) begin
      send_rand(dn_a, px, py);
      dawdle(px, py);
      send_rand(up_a, nudge(px), nudge(py));
    end else if (pick < 80) begin
      send_rand(OP_MIDDLE_DOWN, px, py);
      dawdle(px, py);
      send_rand(OP_MIDDLE_UP, nudge(px), nudge(py));
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) send_rand(op_t'($urandom_range(7)), 16'($urandom()), 16'($urandom()));
    end
  endtask

  task automatic run_phase(input logic [15:0] ticks, input logic [15:0] sx,
                           input logic [15:0] sy, input bit idling, input bit stall);
    settle();
    write_reg(CFG_CHORD_TICKS, ticks);
    write_reg(CFG_SKEW_X, sx);
    write_reg(CFG_SKEW_Y, sy);
    in_idle      = idling;
    out_idle     = idling;
    hold_off_req = stall;
    events_sent  = 0;
    while (events_sent < EVENTS_PER_PHASE) play_gesture();
  endtask

  initial begin
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = CFG_CHORD_TICKS;
    cfg_wdata           = '0;
    ev_in.valid         = 1'b0;
    ev_in.operation     = OP_TICK;
    ev_in.pointer_x     = '0;
    ev_in.pointer_y     = '0;
    ev_in.event_time    = '0;
    ev_in.modifier_keys = '0;
    in_idle             = 1'b0;
    out_idle            = 1'b0;
    hold_off_req        = 1'b0;
    events_sent         = 0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part at reset settings: field extremes and pass-through events
    send_event(OP_MIDDLE_DOWN, 32767, -32768, 32'hFFFF_FFFF, 3'd7);
    send_event(OP_MIDDLE_UP, -32768, 32767, 32'd0, 3'd0);
    send_event(OP_MOVE, 0, 0, 32'd1, 3'd1);
    // tick with the timer stopped: nothing comes out
    send_event(OP_TICK, 0, 0, 32'd2, 3'd2);
    // clean chord, then the partner release is swallowed
    send_event(OP_LEFT_DOWN, 100, 100, 32'd10, 3'd0);
    send_event(OP_RIGHT_DOWN, 101, 99, 32'd11, 3'd4);
    send_event(OP_LEFT_UP, 101, 99, 32'd12, 3'd0);
    send_event(OP_RIGHT_UP, 101, 99, 32'd13, 3'd5);
    // second press on the skew edge: two real presses, then plain releases
    send_event(OP_RIGHT_DOWN, -5, -5, 32'd20, 3'd1);
    send_event(OP_LEFT_DOWN, -3, -5, 32'd21, 3'd2);
    send_event(OP_LEFT_UP, -3, -5, 32'd22, 3'd3);
    send_event(OP_RIGHT_UP, -5, -5, 32'd23, 3'd6);
    // release of the awaited button drops the held press
    send_event(OP_LEFT_DOWN, 0, 0, 32'd30, 3'd0);
    send_event(OP_RIGHT_UP, 0, 0, 32'd31, 3'd7);
    // release while its own press is held: press and release at the release point
    send_event(OP_RIGHT_DOWN, 7, 7, 32'd32, 3'd1);
    send_event(OP_RIGHT_UP, 8, 8, 32'd33, 3'd2);
    // repeated first press, a move inside the window, a move that flushes
    send_event(OP_LEFT_DOWN, 0, 0, 32'd40, 3'd0);
    send_event(OP_LEFT_DOWN, 50, 50, 32'd41, 3'd1);
    send_event(OP_MOVE, 51, 49, 32'd42, 3'd2);
    send_event(OP_MOVE, -32768, 32767, 32'd43, 3'd4);

    // Chord time of zero loads one tick; skew of zero never makes a chord
    settle();
    write_reg(CFG_CHORD_TICKS, 16'd0);
    write_reg(CFG_SKEW_X, 16'd0);
    write_reg(CFG_SKEW_Y, 16'd32767);
    send_event(OP_LEFT_DOWN, 0, 0, 32'd50, 3'd3);
    send_event(OP_TICK, 0, 0, 32'd51, 3'd5);
    send_event(OP_TICK, 0, 0, 32'd52, 3'd6);
    send_event(OP_RIGHT_DOWN, 0, 0, 32'd53, 3'd0);
    send_event(OP_LEFT_DOWN, 0, 0, 32'd54, 3'd7);
    send_event(OP_RIGHT_DOWN, 1, 1, 32'd55, 3'd1);
    send_event(OP_MOVE, 1, 1, 32'd56, 3'd2);

    // Random part across settings; the extremes first, one phase without any idling
    // and one that opens with a long receiver stall
    run_phase(16'd1, 16'd1, 16'd1, 1'b1, 1'b0);
    run_phase(16'd65535, 16'd32767, 16'd32767, 1'b0, 1'b0);
    run_phase(16'd3, 16'd5, 16'd9, 1'b1, 1'b1);
    run_phase(16'd0, 16'h8003, 16'd2, 1'b1, 1'b0);
    run_phase(16'($urandom_range(1, 12)), 16'($urandom_range(1, 30)),
              16'($urandom_range(1, 30)), 1'b1, 1'b0);
    run_phase(CHORD_TICKS_RST, 16'(SKEW_X_RST), 16'(SKEW_Y_RST), 1'b1, 1'b0);

    settle();
    if (mouse_sb.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
